// File: rtl/core/i2cms_pkg.sv
// i2cms_pkg: types, codes and pin table for the i2c master sequencer
// used by the step, the top and the testbench, depends on nothing

package i2cms_pkg;

    localparam int TickW      = 16;
    localparam int ByteW      = 8;
    localparam int InDataW    = 16;
    localparam int OutDataW   = 16;
    localparam logic [TickW-1:0] PhaseTicksReset = 16'd1;
    localparam logic [ByteW-1:0] MsbMask         = 8'h80;
    localparam logic [3:0]       BitsPerByte     = 4'd8;

    localparam logic [1:0] STATUS_ACK    = 2'd0;
    localparam logic [1:0] STATUS_NACK   = 2'd1;
    localparam logic [1:0] STATUS_NO_DEV = 2'd2;

    typedef enum logic [2:0] {
        OP_NONE  = 3'd0,
        OP_START = 3'd1,
        OP_WRITE = 3'd2,
        OP_READ  = 3'd3,
        OP_STOP  = 3'd4
    } op_t;

    typedef enum logic [17:0] {
        PH_IDLE = 18'h00001,
        ST_A    = 18'h00002,
        ST_B    = 18'h00004,
        ST_C    = 18'h00008,
        ST_D    = 18'h00010,
        WB_LO   = 18'h00020,
        WB_HI   = 18'h00040,
        WA_LO   = 18'h00080,
        WA_HI   = 18'h00100,
        WA_END  = 18'h00200,
        RB_LO   = 18'h00400,
        RB_HI   = 18'h00800,
        RK_LO   = 18'h01000,
        RK_HI   = 18'h02000,
        RK_END  = 18'h04000,
        SP_A    = 18'h08000,
        SP_B    = 18'h10000,
        SP_C    = 18'h20000
    } phase_t;

    typedef struct packed {
        phase_t           phase;
        logic [3:0]       bit_left;
        logic [ByteW-1:0] shifter;
        op_t              active_op;
        logic [TickW-1:0] tick_count;
        logic [1:0]       last_status;
        logic [ByteW-1:0] received_byte;
        logic             ack_hold;
        logic             scl_hold_low;
        logic             sda_hold_low;
    } seq_state_t;

    // pull-low levels on entry to a phase: {scl, sda}
    function automatic logic [1:0] pin_levels(input phase_t ph, input logic bit_hi,
                                              input logic ack);
        logic [1:0] r;
        begin
            case (ph)
                ST_A:    r = 2'b10;
                ST_B:    r = 2'b00;
                ST_C:    r = 2'b01;
                ST_D:    r = 2'b11;
                WB_LO:   r = {1'b1, ~bit_hi};
                WB_HI:   r = {1'b0, ~bit_hi};
                WA_LO:   r = 2'b10;
                WA_HI:   r = 2'b00;
                WA_END:  r = 2'b10;
                RB_LO:   r = 2'b10;
                RB_HI:   r = 2'b00;
                RK_LO:   r = {1'b1, ack};
                RK_HI:   r = {1'b0, ack};
                RK_END:  r = 2'b10;
                SP_A:    r = 2'b11;
                SP_B:    r = 2'b01;
                SP_C:    r = 2'b00;
                default: r = 2'b00;
            endcase
            return r;
        end
    endfunction

endpackage

// File: rtl/core/i2cms_step.sv
// i2cms_step: next sequencer state for one tick item
// depends on i2cms_pkg

module i2cms_step (
    input  i2cms_pkg::seq_state_t    cur,
    input  logic [2:0]               cmd,
    input  logic [7:0]               data_byte,
    input  logic                     master_ack,
    input  logic                     scl_sense,
    input  logic                     sda_sense,
    input  logic [i2cms_pkg::TickW-1:0] phase_ticks,
    output i2cms_pkg::seq_state_t    nxt,
    output logic                     done
);

    logic [i2cms_pkg::TickW-1:0] limit;
    logic [i2cms_pkg::TickW-1:0] tick_inc;
    logic [1:0]                  pins;
    logic                        do_enter;
    i2cms_pkg::phase_t           go;

    assign limit    = (phase_ticks == '0) ? i2cms_pkg::PhaseTicksReset : phase_ticks;
    assign tick_inc = cur.tick_count + 1'b1;

    always_comb begin
        nxt      = cur;
        done     = 1'b0;
        do_enter = 1'b0;
        go       = i2cms_pkg::PH_IDLE;
        pins     = 2'b00;
        if (cur.phase == i2cms_pkg::PH_IDLE) begin
            case (cmd)
                i2cms_pkg::OP_START: begin
                    nxt.active_op = i2cms_pkg::OP_START;
                    nxt.shifter   = data_byte;
                    go            = i2cms_pkg::ST_A;
                    do_enter      = 1'b1;
                end
                i2cms_pkg::OP_WRITE: begin
                    nxt.active_op = i2cms_pkg::OP_WRITE;
                    nxt.shifter   = data_byte;
                    nxt.bit_left  = i2cms_pkg::BitsPerByte;
                    go            = i2cms_pkg::WB_LO;
                    do_enter      = 1'b1;
                end
                i2cms_pkg::OP_READ: begin
                    nxt.active_op = i2cms_pkg::OP_READ;
                    nxt.ack_hold  = master_ack;
                    nxt.shifter   = '0;
                    nxt.bit_left  = i2cms_pkg::BitsPerByte;
                    go            = i2cms_pkg::RB_LO;
                    do_enter      = 1'b1;
                end
                i2cms_pkg::OP_STOP: begin
                    nxt.active_op   = i2cms_pkg::OP_STOP;
                    nxt.last_status = i2cms_pkg::STATUS_ACK;
                    go              = i2cms_pkg::SP_A;
                    do_enter        = 1'b1;
                end
                default: begin
                end
            endcase
        end else if (!cur.scl_hold_low && !scl_sense) begin
            // clock stretched by a slave
            nxt.tick_count = '0;
        end else begin
            nxt.tick_count = tick_inc;
            if (tick_inc >= limit) begin
                do_enter = 1'b1;
                case (cur.phase)
                    i2cms_pkg::ST_A:  go = i2cms_pkg::ST_B;
                    i2cms_pkg::ST_B:  go = i2cms_pkg::ST_C;
                    i2cms_pkg::ST_C:  go = i2cms_pkg::ST_D;
                    i2cms_pkg::ST_D: begin
                        nxt.bit_left = i2cms_pkg::BitsPerByte;
                        go           = i2cms_pkg::WB_LO;
                    end
                    i2cms_pkg::WB_LO: go = i2cms_pkg::WB_HI;
                    i2cms_pkg::WB_HI: begin
                        nxt.shifter  = {cur.shifter[6:0], 1'b0};
                        nxt.bit_left = cur.bit_left - 1'b1;
                        go = (nxt.bit_left != '0) ? i2cms_pkg::WB_LO : i2cms_pkg::WA_LO;
                    end
                    i2cms_pkg::WA_LO: go = i2cms_pkg::WA_HI;
                    i2cms_pkg::WA_HI: begin
                        if (cur.active_op == i2cms_pkg::OP_START) begin
                            nxt.last_status = sda_sense ? i2cms_pkg::STATUS_NO_DEV
                                                        : i2cms_pkg::STATUS_ACK;
                        end else begin
                            nxt.last_status = sda_sense ? i2cms_pkg::STATUS_NACK
                                                        : i2cms_pkg::STATUS_ACK;
                        end
                        go = i2cms_pkg::WA_END;
                    end
                    i2cms_pkg::WA_END: begin
                        if (cur.active_op == i2cms_pkg::OP_START &&
                            cur.last_status == i2cms_pkg::STATUS_NO_DEV) begin
                            go = i2cms_pkg::SP_A;
                        end else begin
                            do_enter = 1'b0;
                        end
                    end
                    i2cms_pkg::RB_LO: go = i2cms_pkg::RB_HI;
                    i2cms_pkg::RB_HI: begin
                        nxt.shifter  = {cur.shifter[6:0], sda_sense};
                        nxt.bit_left = cur.bit_left - 1'b1;
                        go = (nxt.bit_left != '0) ? i2cms_pkg::RB_LO : i2cms_pkg::RK_LO;
                    end
                    i2cms_pkg::RK_LO: go = i2cms_pkg::RK_HI;
                    i2cms_pkg::RK_HI: go = i2cms_pkg::RK_END;
                    i2cms_pkg::RK_END: begin
                        nxt.received_byte = cur.shifter;
                        nxt.last_status   = cur.ack_hold ? i2cms_pkg::STATUS_ACK
                                                         : i2cms_pkg::STATUS_NACK;
                        do_enter          = 1'b0;
                    end
                    i2cms_pkg::SP_A:  go = i2cms_pkg::SP_B;
                    i2cms_pkg::SP_B:  go = i2cms_pkg::SP_C;
                    default: do_enter = 1'b0;
                endcase
                if (!do_enter) begin
                    // command complete
                    nxt.phase      = i2cms_pkg::PH_IDLE;
                    nxt.active_op  = i2cms_pkg::OP_NONE;
                    nxt.tick_count = '0;
                    done           = 1'b1;
                end
            end
        end
        if (do_enter) begin
            pins             = i2cms_pkg::pin_levels(go,
                                   (nxt.shifter & i2cms_pkg::MsbMask) != '0, nxt.ack_hold);
            nxt.phase        = go;
            nxt.tick_count   = '0;
            nxt.scl_hold_low = pins[1];
            nxt.sda_hold_low = pins[0];
        end
    end

endmodule

// File: rtl/core/i2c_master_sequencer_unit.sv
// i2c_master_sequencer_unit: open-drain i2c master, one tick per input item
// depends on i2cms_pkg and i2cms_step
//
// usage
//   each item on s_axis is one timing tick carrying the command and the sampled
//   scl/sda levels; each accepted item gives exactly one item on m_axis with the
//   pin drive, busy, done pulse, status and last received byte after that tick
//   commands: start plus address, write byte, read byte, stop; commands arriving
//   while busy are dropped; every pin phase is held phase_ticks ticks (zero as one)
//   and a released scl waits for the line to read high (clock stretching)
//   result: registered, on m_axis in the cycle after the item is accepted
//   throughput: one item per cycle unless stalled; the sequencer state updates in the
//   same cycle the item is taken, from the item, the state register and phase_ticks
//   stall: while m_axis_tready is low the result holds in the output register;
//   one item is still taken if the output register is empty or draining
//   reset: aresetn low clears the sequencer to idle with both lines released, empties
//   the output register and sets phase_ticks to 1; cfg_we writes phase_ticks from
//   cfg_wdata; users must write only while no item is in flight (block does not check)

module i2c_master_sequencer_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [i2cms_pkg::TickW-1:0]       cfg_wdata,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // cmd[2:0], data_byte[10:3], master_ack[11], scl_sense[12], sda_sense[13], zero pad
    input  logic [i2cms_pkg::InDataW-1:0]     s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // scl_pull_low[0], sda_pull_low[1], busy_res[2], done_res[3], status[5:4],
    // read_data[13:6], zero pad
    output logic [i2cms_pkg::OutDataW-1:0]    m_axis_tdata
);

    i2cms_pkg::seq_state_t         state_reg, state_next;
    logic [i2cms_pkg::TickW-1:0]   phase_ticks_reg;
    logic                          m_valid_reg;
    logic [i2cms_pkg::OutDataW-1:0] m_data_reg, m_data_next;
    logic                          done;
    logic                          accept;

    assign s_axis_tready = !m_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    i2cms_step u_step (
        .cur         (state_reg),
        .cmd         (s_axis_tdata[2:0]),
        .data_byte   (s_axis_tdata[10:3]),
        .master_ack  (s_axis_tdata[11]),
        .scl_sense   (s_axis_tdata[12]),
        .sda_sense   (s_axis_tdata[13]),
        .phase_ticks (phase_ticks_reg),
        .nxt         (state_next),
        .done        (done)
    );

    assign m_data_next = {2'b00, state_next.received_byte, state_next.last_status, done,
                          state_next.phase != i2cms_pkg::PH_IDLE,
                          state_next.sda_hold_low, state_next.scl_hold_low};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_ticks_reg <= i2cms_pkg::PhaseTicksReset;
        end else if (cfg_we) begin
            phase_ticks_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.phase         <= i2cms_pkg::PH_IDLE;
            state_reg.bit_left      <= '0;
            state_reg.shifter       <= '0;
            state_reg.active_op     <= i2cms_pkg::OP_NONE;
            state_reg.tick_count    <= '0;
            state_reg.last_status   <= i2cms_pkg::STATUS_ACK;
            state_reg.received_byte <= '0;
            state_reg.ack_hold      <= 1'b0;
            state_reg.scl_hold_low  <= 1'b0;
            state_reg.sda_hold_low  <= 1'b0;
        end else if (accept) begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_data_reg <= m_data_next;
        end
    end

endmodule

// File: rtl/core/i2cms_checker.sv
// i2cms_checker: port-level checks for i2c_master_sequencer_unit, bound to the top
// depends on i2c_master_sequencer_unit ports only

module i2cms_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata
);

    // result held while stalled
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // completion pulse only when the sequencer has gone idle
    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tdata[3] |-> !m_axis_tdata[2])
        else $error("done with busy set");

    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> m_axis_tdata[5:4] != 2'b11)
        else $error("status code out of range");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("output valid after reset");

    // a consumed item is replaced without waiting
    a_accept_next: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_axis_tvalid || m_axis_tready |-> s_axis_tready)
        else $error("input not ready with output free");

endmodule

bind i2c_master_sequencer_unit i2cms_checker u_i2cms_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// File: dv/testbench.sv
`timescale 1ns / 1ps
// testbench for i2c_master_sequencer_unit: drives timing ticks with bus-like senses
// and checks every pin report against a cycle-free model of the sequencer
// depends on i2cms_pkg and the rtl of the block

module testbench;

    localparam logic [2:0] CMD_RSVD_LO = 3'd5;
    localparam logic [2:0] CMD_RSVD_HI = 3'd7;
    localparam int HOLDOFF_CYCLES = 48;
    localparam int RANDOM_ITEMS_PER_SETTING = 215;

    typedef logic [i2cms_pkg::ByteW-1:0] byte_t;
    typedef logic [2:0]                  cmd_t;

    typedef struct packed {
        logic             sda_sense;
        logic             scl_sense;
        logic             master_ack;
        byte_t            data_byte;
        cmd_t             cmd;
    } tick_t;

    typedef struct packed {
        byte_t            read_data;
        logic [1:0]       status;
        logic             done;
        logic             busy;
        logic             sda_low;
        logic             scl_low;
    } pin_report_t;

    typedef struct {
        i2cms_pkg::phase_t                ph;
        logic [3:0]                       bits_left;
        byte_t                            shreg;
        i2cms_pkg::op_t                   op;
        logic [i2cms_pkg::TickW-1:0]      ticks;
        logic [1:0]                       status;
        byte_t                            rx_byte;
        logic                             ack_drive;
        logic                             scl_low;
        logic                             sda_low;
    } bus_state_t;

    logic                              aclk;
    logic                              aresetn;
    logic                              cfg_we;
    logic [i2cms_pkg::TickW-1:0]       cfg_wdata;
    logic                              s_axis_tvalid;
    logic                              s_axis_tready;
    logic [i2cms_pkg::InDataW-1:0]     s_axis_tdata;
    logic                              m_axis_tvalid;
    logic                              m_axis_tready;
    logic [i2cms_pkg::OutDataW-1:0]    m_axis_tdata;

    bus_state_t                        bus;
    logic [i2cms_pkg::TickW-1:0]       phase_limit;
    logic                              done_now;
    pin_report_t                       pending_reports[$];
    int                                mismatches = 0;
    int                                items_sent = 0;
    int                                ack_pct = 100;
    int                                stretch_pct = 10;
    int                                sda_high_pct = 50;
    bit                                steady = 1'b0;
    bit                                holdoff_req = 1'b0;
    logic                              rx_blocked;

    i2c_master_sequencer_unit u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial aclk = 1'b0;
    always #6 aclk = ~aclk;

    function automatic void enter_phase(i2cms_pkg::phase_t p);
        logic bit_low;
        bit_low = ((bus.shreg & i2cms_pkg::MsbMask) == 0);
        bus.ph = p;
        bus.ticks = '0;
        case (p)
            i2cms_pkg::ST_A:   {bus.scl_low, bus.sda_low} = 2'b10;
            i2cms_pkg::ST_B:   {bus.scl_low, bus.sda_low} = 2'b00;
            i2cms_pkg::ST_C:   {bus.scl_low, bus.sda_low} = 2'b01;
            i2cms_pkg::ST_D:   {bus.scl_low, bus.sda_low} = 2'b11;
            i2cms_pkg::WB_LO:  {bus.scl_low, bus.sda_low} = {1'b1, bit_low};
            i2cms_pkg::WB_HI:  {bus.scl_low, bus.sda_low} = {1'b0, bit_low};
            i2cms_pkg::WA_LO:  {bus.scl_low, bus.sda_low} = 2'b10;
            i2cms_pkg::WA_HI:  {bus.scl_low, bus.sda_low} = 2'b00;
            i2cms_pkg::WA_END: {bus.scl_low, bus.sda_low} = 2'b10;
            i2cms_pkg::RB_LO:  {bus.scl_low, bus.sda_low} = 2'b10;
            i2cms_pkg::RB_HI:  {bus.scl_low, bus.sda_low} = 2'b00;
            i2cms_pkg::RK_LO:  {bus.scl_low, bus.sda_low} = {1'b1, bus.ack_drive};
            i2cms_pkg::RK_HI:  {bus.scl_low, bus.sda_low} = {1'b0, bus.ack_drive};
            i2cms_pkg::RK_END: {bus.scl_low, bus.sda_low} = 2'b10;
            i2cms_pkg::SP_A:   {bus.scl_low, bus.sda_low} = 2'b11;
            i2cms_pkg::SP_B:   {bus.scl_low, bus.sda_low} = 2'b01;
            i2cms_pkg::SP_C:   {bus.scl_low, bus.sda_low} = 2'b00;
            default:           bus.ph = i2cms_pkg::PH_IDLE;
        endcase
    endfunction

    function automatic void complete_command();
        bus.ph = i2cms_pkg::PH_IDLE;
        bus.op = i2cms_pkg::OP_NONE;
        bus.ticks = '0;
        done_now = 1'b1;
    endfunction

    function automatic void advance_phase(logic sda);
        case (bus.ph)
            i2cms_pkg::ST_A:  enter_phase(i2cms_pkg::ST_B);
            i2cms_pkg::ST_B:  enter_phase(i2cms_pkg::ST_C);
            i2cms_pkg::ST_C:  enter_phase(i2cms_pkg::ST_D);
            i2cms_pkg::ST_D: begin
                bus.bits_left = i2cms_pkg::BitsPerByte;
                enter_phase(i2cms_pkg::WB_LO);
            end
            i2cms_pkg::WB_LO: enter_phase(i2cms_pkg::WB_HI);
            i2cms_pkg::WB_HI: begin
                bus.shreg = bus.shreg << 1;
                bus.bits_left = bus.bits_left - 1'b1;
                if (bus.bits_left != 0) enter_phase(i2cms_pkg::WB_LO);
                else enter_phase(i2cms_pkg::WA_LO);
            end
            i2cms_pkg::WA_LO: enter_phase(i2cms_pkg::WA_HI);
            i2cms_pkg::WA_HI: begin
                if (bus.op == i2cms_pkg::OP_START) begin
                    bus.status = sda ? i2cms_pkg::STATUS_NO_DEV : i2cms_pkg::STATUS_ACK;
                end else begin
                    bus.status = sda ? i2cms_pkg::STATUS_NACK : i2cms_pkg::STATUS_ACK;
                end
                enter_phase(i2cms_pkg::WA_END);
            end
            i2cms_pkg::WA_END: begin
                if (bus.op == i2cms_pkg::OP_START && bus.status == i2cms_pkg::STATUS_NO_DEV)
                    enter_phase(i2cms_pkg::SP_A);
                else complete_command();
            end
            i2cms_pkg::RB_LO: enter_phase(i2cms_pkg::RB_HI);
            i2cms_pkg::RB_HI: begin
                bus.shreg = {bus.shreg[i2cms_pkg::ByteW-2:0], sda};
                bus.bits_left = bus.bits_left - 1'b1;
                if (bus.bits_left != 0) enter_phase(i2cms_pkg::RB_LO);
                else enter_phase(i2cms_pkg::RK_LO);
            end
            i2cms_pkg::RK_LO: enter_phase(i2cms_pkg::RK_HI);
            i2cms_pkg::RK_HI: enter_phase(i2cms_pkg::RK_END);
            i2cms_pkg::RK_END: begin
                bus.rx_byte = bus.shreg;
                bus.status = bus.ack_drive ? i2cms_pkg::STATUS_ACK : i2cms_pkg::STATUS_NACK;
                complete_command();
            end
            i2cms_pkg::SP_A:  enter_phase(i2cms_pkg::SP_B);
            i2cms_pkg::SP_B:  enter_phase(i2cms_pkg::SP_C);
            default: complete_command();
        endcase
    endfunction

    function automatic pin_report_t sequencer_tick(tick_t t);
        pin_report_t r;
        logic [i2cms_pkg::TickW-1:0] lim;
        done_now = 1'b0;
        if (bus.ph == i2cms_pkg::PH_IDLE) begin
            case (t.cmd)
                i2cms_pkg::OP_START: begin
                    bus.op = i2cms_pkg::OP_START;
                    bus.shreg = t.data_byte;
                    enter_phase(i2cms_pkg::ST_A);
                end
                i2cms_pkg::OP_WRITE: begin
                    bus.op = i2cms_pkg::OP_WRITE;
                    bus.shreg = t.data_byte;
                    bus.bits_left = i2cms_pkg::BitsPerByte;
                    enter_phase(i2cms_pkg::WB_LO);
                end
                i2cms_pkg::OP_READ: begin
                    bus.op = i2cms_pkg::OP_READ;
                    bus.ack_drive = t.master_ack;
                    bus.shreg = '0;
                    bus.bits_left = i2cms_pkg::BitsPerByte;
                    enter_phase(i2cms_pkg::RB_LO);
                end
                i2cms_pkg::OP_STOP: begin
                    bus.op = i2cms_pkg::OP_STOP;
                    bus.status = i2cms_pkg::STATUS_ACK;
                    enter_phase(i2cms_pkg::SP_A);
                end
                default: ;
            endcase
        end else if (!bus.scl_low && !t.scl_sense) begin
            bus.ticks = '0;
        end else begin
            lim = (phase_limit == 0) ? 16'd1 : phase_limit;
            bus.ticks = bus.ticks + 1'b1;
            if (bus.ticks >= lim) advance_phase(t.sda_sense);
        end
        r.scl_low = bus.scl_low;
        r.sda_low = bus.sda_low;
        r.busy = (bus.ph != i2cms_pkg::PH_IDLE);
        r.done = done_now;
        r.status = bus.status;
        r.read_data = bus.rx_byte;
        return r;
    endfunction

    // senses are drawn at random, with stretching on released scl and a chosen ack rate
    function automatic tick_t make_tick(cmd_t cmd, byte_t data, logic mack);
        tick_t t;
        t.cmd = cmd;
        t.data_byte = data;
        t.master_ack = mack;
        if (bus.scl_low) t.scl_sense = 1'($urandom_range(0, 1));
        else t.scl_sense = ($urandom_range(1, 100) > stretch_pct);
        if (bus.ph == i2cms_pkg::WA_HI) t.sda_sense = ($urandom_range(1, 100) > ack_pct);
        else t.sda_sense = ($urandom_range(1, 100) <= sda_high_pct);
        return t;
    endfunction

    task automatic send_tick(tick_t t);
        s_axis_tdata <= {2'b00, t};
        s_axis_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        pending_reports.push_back(sequencer_tick(t));
        items_sent++;
        if (!steady && $urandom_range(0, 4) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
    endtask

    task automatic finish_command();
        cmd_t noise;
        while (bus.ph != i2cms_pkg::PH_IDLE) begin
            noise = ($urandom_range(0, 3) == 0) ? cmd_t'($urandom_range(0, 7))
                                                 : i2cms_pkg::OP_NONE;
            send_tick(make_tick(noise, byte_t'($urandom), 1'($urandom)));
        end
    endtask

    task automatic issue(cmd_t cmd, byte_t data, logic mack);
        send_tick(make_tick(cmd, data, mack));
        finish_command();
    endtask

    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge aclk);
        repeat (2) @(posedge aclk);
    endtask

    task automatic set_phase_ticks(logic [i2cms_pkg::TickW-1:0] v);
        cfg_wdata <= v;
        cfg_we <= 1'b1;
        @(posedge aclk);
        cfg_we <= 1'b0;
        phase_limit = v;
    endtask

    task automatic test_ack_paths();
        ack_pct = 100;
        issue(i2cms_pkg::OP_START, 8'h00, 1'b0);
        issue(i2cms_pkg::OP_WRITE, 8'hFF, 1'b0);
        issue(i2cms_pkg::OP_WRITE, 8'h00, 1'b1);
        sda_high_pct = 100;
        issue(i2cms_pkg::OP_READ, 8'h00, 1'b1);
        sda_high_pct = 0;
        issue(i2cms_pkg::OP_READ, 8'hFF, 1'b0);
        sda_high_pct = 50;
        issue(i2cms_pkg::OP_STOP, 8'h00, 1'b0);
    endtask

    task automatic test_no_device();
        ack_pct = 0;
        issue(i2cms_pkg::OP_START, 8'hFF, 1'b1);
        issue(i2cms_pkg::OP_WRITE, 8'h5A, 1'b0);
        issue(i2cms_pkg::OP_READ, 8'hC3, 1'b1);
        issue(i2cms_pkg::OP_STOP, 8'hFF, 1'b1);
        ack_pct = 100;
    endtask

    task automatic test_repeated_start();
        issue(i2cms_pkg::OP_START, 8'hA0, 1'b0);
        issue(i2cms_pkg::OP_WRITE, 8'h81, 1'b0);
        issue(i2cms_pkg::OP_START, 8'hA1, 1'b1);
        issue(i2cms_pkg::OP_READ, 8'h00, 1'b0);
        issue(i2cms_pkg::OP_STOP, 8'h00, 1'b0);
    endtask

    task automatic test_ignored_codes();
        cmd_t code;
        for (int c = CMD_RSVD_LO; c <= CMD_RSVD_HI; c++) begin
            send_tick(make_tick(cmd_t'(c), byte_t'($urandom), 1'b1));
        end
        send_tick(make_tick(i2cms_pkg::OP_NONE, 8'hFF, 1'b1));
        send_tick(make_tick(i2cms_pkg::OP_WRITE, 8'h3C, 1'b1));
        code = i2cms_pkg::OP_NONE;
        while (bus.ph != i2cms_pkg::PH_IDLE) begin
            send_tick(make_tick(code, byte_t'($urandom), 1'($urandom)));
            code = code + 1'b1;
        end
    endtask

    task automatic test_clock_stretch();
        stretch_pct = 75;
        issue(i2cms_pkg::OP_START, 8'h42, 1'b0);
        issue(i2cms_pkg::OP_WRITE, 8'h99, 1'b0);
        issue(i2cms_pkg::OP_READ, 8'h00, 1'b1);
        issue(i2cms_pkg::OP_STOP, 8'h00, 1'b0);
        stretch_pct = 10;
    endtask

    task automatic test_tick_extremes();
        settle();
        set_phase_ticks(16'd0);
        issue(i2cms_pkg::OP_WRITE, 8'hA5, 1'b0);
        settle();
        set_phase_ticks(16'hFFFF);
        send_tick(make_tick(i2cms_pkg::OP_START, 8'h6E, 1'b0));
        repeat (30) send_tick(make_tick(i2cms_pkg::OP_NONE, byte_t'($urandom), 1'($urandom)));
        settle();
        set_phase_ticks(16'd2);
        finish_command();
        issue(i2cms_pkg::OP_STOP, 8'h00, 1'b0);
        settle();
        set_phase_ticks(i2cms_pkg::PhaseTicksReset);
    endtask

    task automatic test_backpressure();
        holdoff_req = 1'b1;
        issue(i2cms_pkg::OP_START, byte_t'($urandom), 1'b0);
        issue(i2cms_pkg::OP_WRITE, byte_t'($urandom), 1'b0);
        issue(i2cms_pkg::OP_READ, byte_t'($urandom), 1'b1);
        issue(i2cms_pkg::OP_STOP, byte_t'($urandom), 1'b0);
    endtask

    task automatic random_exchange();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll == 0) begin
            if ($urandom_range(0, 1)) begin
                send_tick(make_tick(i2cms_pkg::OP_NONE, byte_t'($urandom), 1'($urandom)));
            end else begin
                send_tick(make_tick(cmd_t'($urandom_range(CMD_RSVD_LO, CMD_RSVD_HI)),
                                    byte_t'($urandom), 1'($urandom)));
            end
        end else if (roll == 1) begin
            issue(cmd_t'($urandom_range(i2cms_pkg::OP_WRITE, i2cms_pkg::OP_STOP)),
                  byte_t'($urandom), 1'($urandom));
        end else begin
            ack_pct = ($urandom_range(0, 4) == 0) ? 0 : 90;
            issue(i2cms_pkg::OP_START, byte_t'($urandom), 1'($urandom));
            if (bus.status != i2cms_pkg::STATUS_NO_DEV) begin
                repeat ($urandom_range(0, 3)) begin
                    if ($urandom_range(0, 1)) begin
                        issue(i2cms_pkg::OP_WRITE, byte_t'($urandom), 1'($urandom));
                    end else begin
                        issue(i2cms_pkg::OP_READ, byte_t'($urandom), 1'($urandom));
                    end
                end
                if ($urandom_range(0, 4) != 0) begin
                    issue(i2cms_pkg::OP_STOP, byte_t'($urandom), 1'($urandom));
                end
            end
        end
    endtask

    task automatic test_random();
        logic [i2cms_pkg::TickW-1:0] settings[5];
        int stop_at;
        settings = '{16'd3, 16'd1, 16'd2, 16'd4, 16'd1};
        foreach (settings[i]) begin
            settle();
            set_phase_ticks(settings[i]);
            steady = (i == 4);
            stop_at = items_sent + RANDOM_ITEMS_PER_SETTING;
            while (items_sent < stop_at) random_exchange();
        end
    endtask

    function automatic void check_field(string name, int unsigned want, int unsigned seen);
        if (want != seen) begin
            $error("%s expected %0d got %0d", name, want, seen);
            mismatches++;
        end
    endfunction

    initial begin
        pin_report_t want;
        pin_report_t seen;
        int stall_left;
        stall_left = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(posedge aclk);
            if (m_axis_tvalid && m_axis_tready) begin
                seen = pin_report_t'(m_axis_tdata[13:0]);
                if (pending_reports.size() == 0) begin
                    $error("result item with nothing pending");
                    mismatches++;
                end else begin
                    want = pending_reports.pop_front();
                    check_field("scl_pull_low", 32'(want.scl_low), 32'(seen.scl_low));
                    check_field("sda_pull_low", 32'(want.sda_low), 32'(seen.sda_low));
                    check_field("busy_res", 32'(want.busy), 32'(seen.busy));
                    check_field("done_res", 32'(want.done), 32'(seen.done));
                    check_field("status", 32'(want.status), 32'(seen.status));
                    check_field("read_data", 32'(want.read_data), 32'(seen.read_data));
                end
            end
            if (!aresetn || rx_blocked) begin
                m_axis_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else if (!steady && $urandom_range(0, 6) == 0) begin
                stall_left = $urandom_range(0, 2);
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // long receiver hold-off so the output register fills and the input stalls
    initial begin
        rx_blocked = 1'b0;
        forever begin
            @(posedge aclk);
            if (holdoff_req) begin
                rx_blocked <= 1'b1;
                repeat (HOLDOFF_CYCLES) @(posedge aclk);
                rx_blocked <= 1'b0;
                holdoff_req = 1'b0;
            end
        end
    end

    initial begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

    initial begin
        aresetn = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        bus = '{ph: i2cms_pkg::PH_IDLE, bits_left: '0, shreg: '0, op: i2cms_pkg::OP_NONE,
                ticks: '0, status: i2cms_pkg::STATUS_ACK, rx_byte: '0, ack_drive: 1'b0,
                scl_low: 1'b0, sda_low: 1'b0};
        phase_limit = i2cms_pkg::PhaseTicksReset;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_ack_paths();
        test_no_device();
        test_repeated_start();
        test_ignored_codes();
        test_clock_stretch();
        test_tick_extremes();
        test_backpressure();
        test_random();
        settle();
        repeat (4) @(posedge aclk);
        if (mismatches == 0) $display("tb: success");
        else $display("tb: failure");
        $finish;
    end

endmodule
